FILE: design/llrb_pkg.sv
package llrb_pkg;

  // Ring geometry and burst size.
  localparam int BUFFER_BYTES     = 8192;
  localparam int BURST_BYTES      = 64;
  localparam int NEAR_FULL_MARGIN = 64;
  localparam int PTR_W            = $clog2(BUFFER_BYTES);
  localparam int LEN_W            = 14;
  localparam int BURST_W          = $clog2(BURST_BYTES + 1);
  localparam int CMP_W            = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // Request kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [BURST_W-1:0] burst_cnt_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic             first_of_line;
    logic             last_of_line;
    logic [LEN_W-1:0] line_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_of_burst;
  } out_item_t;

  // Access to the ring memory for the current cycle.
  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
    logic       re;
    ptr_t       raddr;
  } mem_req_t;

  // Load of one drained byte into the output stage.
  typedef struct packed {
    logic      load;
    out_item_t data;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE_START,
    ST_DROP_CHECK,
    ST_DROP_RD,
    ST_DROP_WAIT,
    ST_PUT,
    ST_PUT_NL,
    ST_FLUSH_START,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_t;

  // Advance a ring pointer by one with wrap.
  function automatic ptr_t bump(input ptr_t p);
    if (p == ptr_t'(BUFFER_BYTES - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

FILE: design/llrb_ram.sv
module llrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/llrb_out_stage.sv
module llrb_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  llrb_pkg::emit_t     emit,
  output logic                out_free,
  output logic                result_valid,
  input  logic                result_ready,
  output llrb_pkg::out_item_t result
);

  // The stage can take a new byte when it is empty or being emptied now.
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      result <= emit.data;
    end
  end

endmodule

FILE: design/llrb_ctrl.sv
module llrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  llrb_pkg::in_item_t item,
  output llrb_pkg::mem_req_t mem_req,
  input  logic [7:0]         rdata,
  output llrb_pkg::emit_t    emit,
  input  logic               out_free
);

  llrb_pkg::state_t     state, state_next;
  llrb_pkg::ptr_t       wp, wp_next;
  llrb_pkg::ptr_t       rp, rp_next;
  logic                 discarding, discarding_next;
  llrb_pkg::in_item_t   cur, cur_next;
  llrb_pkg::ptr_t       scan_ptr, scan_ptr_next;
  llrb_pkg::burst_cnt_t idx, idx_next;
  llrb_pkg::burst_cnt_t limit, limit_next;
  logic                 seen, seen_next;
  llrb_pkg::burst_cnt_t last_nl, last_nl_next;
  llrb_pkg::burst_cnt_t send, send_next;
  llrb_pkg::burst_cnt_t cnt, cnt_next;

  llrb_pkg::ptr_t                 used;
  llrb_pkg::ptr_t                 free_bytes;
  logic [llrb_pkg::PTR_W:0]       used_wrap;
  logic [llrb_pkg::CMP_W-1:0]     need;
  logic                           too_long;
  logic                           room_ok;
  logic                           near_full;
  llrb_pkg::burst_cnt_t           limit_now;

  // Fill level of the ring and the room checks for the current line.
  assign used_wrap  = {1'b0, wp} + (llrb_pkg::PTR_W + 1)'(llrb_pkg::BUFFER_BYTES)
                      - {1'b0, rp};
  assign used       = (wp >= rp) ? (wp - rp) : used_wrap[llrb_pkg::PTR_W-1:0];
  assign free_bytes = llrb_pkg::ptr_t'(llrb_pkg::BUFFER_BYTES - 1) - used;
  assign need       = llrb_pkg::CMP_W'(cur.line_length) + llrb_pkg::CMP_W'(1);
  assign too_long   = (cur.line_length == '0)
                      || (need > llrb_pkg::CMP_W'(llrb_pkg::BUFFER_BYTES - 1));
  assign room_ok    = llrb_pkg::CMP_W'(free_bytes) >= need;
  assign near_full  = llrb_pkg::CMP_W'(used)
                      >= llrb_pkg::CMP_W'(llrb_pkg::BUFFER_BYTES - llrb_pkg::NEAR_FULL_MARGIN);
  assign limit_now  = (llrb_pkg::CMP_W'(used) < llrb_pkg::CMP_W'(llrb_pkg::BURST_BYTES))
                      ? llrb_pkg::burst_cnt_t'(used)
                      : llrb_pkg::burst_cnt_t'(llrb_pkg::BURST_BYTES);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= llrb_pkg::ST_IDLE;
      wp         <= '0;
      rp         <= '0;
      discarding <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      discarding <= discarding_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_ptr <= scan_ptr_next;
    idx      <= idx_next;
    limit    <= limit_next;
    seen     <= seen_next;
    last_nl  <= last_nl_next;
    send     <= send_next;
    cnt      <= cnt_next;
  end

  // Sequencer: store bytes, discard overlong lines, drop old lines, scan and drain on flush.
  always_comb begin
    state_next      = state;
    wp_next         = wp;
    rp_next         = rp;
    discarding_next = discarding;
    cur_next        = cur;
    scan_ptr_next   = scan_ptr;
    idx_next        = idx;
    limit_next      = limit;
    seen_next       = seen;
    last_nl_next    = last_nl;
    send_next       = send;
    cnt_next        = cnt;
    item_ready      = 1'b0;
    mem_req         = '0;
    emit            = '0;

    unique case (state)
      llrb_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cur_next   = item;
          state_next = (item.kind == llrb_pkg::KIND_FLUSH) ? llrb_pkg::ST_FLUSH_START
                                                            : llrb_pkg::ST_BYTE_START;
        end
      end

      llrb_pkg::ST_BYTE_START: begin
        priority if (cur.first_of_line && too_long) begin
          // The line is empty or can never fit: ignore it up to its last byte.
          discarding_next = !cur.last_of_line;
          state_next      = llrb_pkg::ST_IDLE;
        end else if (cur.first_of_line) begin
          discarding_next = 1'b0;
          state_next      = llrb_pkg::ST_DROP_CHECK;
        end else if (discarding) begin
          if (cur.last_of_line) begin
            discarding_next = 1'b0;
          end
          state_next = llrb_pkg::ST_IDLE;
        end else begin
          state_next = llrb_pkg::ST_PUT;
        end
      end

      llrb_pkg::ST_DROP_CHECK: begin
        state_next = room_ok ? llrb_pkg::ST_PUT : llrb_pkg::ST_DROP_RD;
      end

      llrb_pkg::ST_DROP_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rp;
        state_next    = llrb_pkg::ST_DROP_WAIT;
      end

      llrb_pkg::ST_DROP_WAIT: begin
        // One byte of the oldest line leaves; a newline or an empty ring ends the line.
        rp_next = llrb_pkg::bump(rp);
        if (rdata == llrb_pkg::NEWLINE_CODE || llrb_pkg::bump(rp) == wp) begin
          state_next = llrb_pkg::ST_DROP_CHECK;
        end else begin
          state_next = llrb_pkg::ST_DROP_RD;
        end
      end

      llrb_pkg::ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wp;
        mem_req.wdata = cur.data_byte;
        wp_next       = llrb_pkg::bump(wp);
        if (llrb_pkg::bump(wp) == rp) begin
          rp_next = llrb_pkg::bump(rp);
        end
        state_next = cur.last_of_line ? llrb_pkg::ST_PUT_NL : llrb_pkg::ST_IDLE;
      end

      llrb_pkg::ST_PUT_NL: begin
        mem_req.we      = 1'b1;
        mem_req.waddr   = wp;
        mem_req.wdata   = llrb_pkg::NEWLINE_CODE;
        wp_next         = llrb_pkg::bump(wp);
        if (llrb_pkg::bump(wp) == rp) begin
          rp_next = llrb_pkg::bump(rp);
        end
        discarding_next = 1'b0;
        state_next      = llrb_pkg::ST_IDLE;
      end

      llrb_pkg::ST_FLUSH_START: begin
        limit_next    = limit_now;
        scan_ptr_next = rp;
        idx_next      = '0;
        seen_next     = 1'b0;
        last_nl_next  = '0;
        state_next    = (used == '0) ? llrb_pkg::ST_IDLE : llrb_pkg::ST_SCAN_RD;
      end

      llrb_pkg::ST_SCAN_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = scan_ptr;
        state_next    = llrb_pkg::ST_SCAN_WAIT;
      end

      llrb_pkg::ST_SCAN_WAIT: begin
        if (rdata == llrb_pkg::NEWLINE_CODE) begin
          seen_next    = 1'b1;
          last_nl_next = idx;
        end
        scan_ptr_next = llrb_pkg::bump(scan_ptr);
        idx_next      = idx + llrb_pkg::burst_cnt_t'(1);
        state_next    = (idx + llrb_pkg::burst_cnt_t'(1) == limit) ? llrb_pkg::ST_DECIDE
                                                                    : llrb_pkg::ST_SCAN_RD;
      end

      llrb_pkg::ST_DECIDE: begin
        cnt_next = '0;
        priority if (seen) begin
          send_next  = last_nl + llrb_pkg::burst_cnt_t'(1);
          state_next = llrb_pkg::ST_EMIT_RD;
        end else if (near_full) begin
          send_next  = limit;
          state_next = llrb_pkg::ST_EMIT_RD;
        end else begin
          state_next = llrb_pkg::ST_IDLE;
        end
      end

      llrb_pkg::ST_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rp;
        state_next    = llrb_pkg::ST_EMIT_WAIT;
      end

      llrb_pkg::ST_EMIT_WAIT: begin
        // Hold the read byte until the output stage has room for it.
        if (out_free) begin
          emit.load               = 1'b1;
          emit.data.data_out      = rdata;
          emit.data.last_of_burst = (cnt + llrb_pkg::burst_cnt_t'(1) == send);
          rp_next                 = llrb_pkg::bump(rp);
          cnt_next                = cnt + llrb_pkg::burst_cnt_t'(1);
          state_next = (cnt + llrb_pkg::burst_cnt_t'(1) == send) ? llrb_pkg::ST_IDLE
                                                                  : llrb_pkg::ST_EMIT_RD;
        end
      end

      default: begin
        state_next = llrb_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("ring memory read and written in the same cycle");

  a_put_leaves_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == llrb_pkg::ST_PUT) |=> (wp != rp))
    else $error("ring reads empty right after a byte was stored");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> out_free)
    else $error("output stage loaded while it still holds an unsent byte");

  a_drop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == llrb_pkg::ST_DROP_RD) |-> (rp != wp))
    else $error("line drop started on an empty ring");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    (state == llrb_pkg::ST_EMIT_WAIT) |-> (cnt < send && send != '0))
    else $error("drain count ran past the burst length");
`endif

endmodule

FILE: design/line_log_ring_buffer.sv
// Line log ring buffer.
// The item channel (item_valid, item_ready, item) carries one text byte or one
// flush request per transfer. Text bytes are stored in an 8-bit ring with one
// slot kept free; the first byte of a line drops the oldest whole lines until
// the line and its newline fit, and a newline is stored after the last byte.
// A flush scans up to BURST_BYTES bytes from the oldest end and drains through
// the last newline it finds, or the whole window when the ring is nearly full.
// Drained bytes leave on the result channel (result_valid, result_ready,
// result), oldest first, with last_of_burst on the final byte.
// One request is handled at a time: item_ready is high only in the idle state,
// so a new request is not taken before the last one is through. Each ring
// read is registered in the memory, so every dropped, scanned or drained byte
// takes a read state and then a wait state; a flush first sets up its scan
// window and ends in a decide state that chooses how many bytes to drain.
// When the receiver stalls, the drained byte waits in the output register and
// the drain pauses; item_ready stays low until the last byte is loaded there.
// Synchronous reset empties the ring and ends any discarded line; memory
// contents are not cleared, since only written entries are ever read.
module line_log_ring_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  llrb_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output llrb_pkg::out_item_t result
);

  llrb_pkg::mem_req_t mem_req;
  llrb_pkg::emit_t    emit;
  logic [7:0]         rdata;
  logic               out_free;

  llrb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .emit       (emit),
    .out_free   (out_free)
  );

  llrb_ram #(
    .WIDTH (8),
    .DEPTH (llrb_pkg::BUFFER_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  llrb_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
